>>> hdl/b2b_pkg.sv
// Package for the BLAKE2b-256 hash block: constants, IV, message schedule, G function.
// No dependencies.
package b2b_pkg;

  localparam int DigestWordsDefault = 4;
  localparam logic [63:0] ParamBase = 64'h0000_0000_0101_0000;

  localparam int NumRounds = 12;
  localparam int RoundW = 4;

  function automatic logic [63:0] iv_word(input logic [2:0] idx);
    logic [63:0] r;
    unique case (idx)
      3'd0: r = 64'h6a09e667f3bcc908;
      3'd1: r = 64'hbb67ae8584caa73b;
      3'd2: r = 64'h3c6ef372fe94f82b;
      3'd3: r = 64'ha54ff53a5f1d36f1;
      3'd4: r = 64'h510e527fade682d1;
      3'd5: r = 64'h9b05688c2b3e6c1f;
      3'd6: r = 64'h1f83d9abfb41bd6b;
      default: r = 64'h5be0cd19137e2179;
    endcase
    return r;
  endfunction

  // Message schedule: row r mod 10, returns 16 4-bit indexes, entry 0 in low bits.
  function automatic logic [63:0] sigma_row(input logic [3:0] rnd);
    logic [63:0] r;
    unique case (rnd)
      4'd0, 4'd10: r = 64'hfedcba9876543210;
      4'd1, 4'd11: r = 64'h357b20c16df984ae;
      4'd2: r = 64'h491763eadf250c8b;
      4'd3: r = 64'h8f04a562ebcd1397;
      4'd4: r = 64'hd386cb1efa427509;
      4'd5: r = 64'h91ef57d438b0a6c2;
      4'd6: r = 64'hb8293670a4def15c;
      4'd7: r = 64'ha2684f05931ce7bd;
      4'd8: r = 64'h5a417d2c803b9ef6;
      default: r = 64'h0dc3e9bf5167482a;
    endcase
    return r;
  endfunction

  typedef struct packed {
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] c;
    logic [63:0] d;
  } quad_t;

  // Half of G: one add/xor/rotate chain with either (32,24) or (16,63) rotations.
  function automatic quad_t g_half(input quad_t q, input logic [63:0] m, input logic second);
    quad_t o;
    logic [63:0] t;
    o.a = q.a + q.b + m;
    t = q.d ^ o.a;
    o.d = second ? {t[15:0], t[63:16]} : {t[31:0], t[63:32]};
    o.c = q.c + o.d;
    t = q.b ^ o.c;
    o.b = second ? {t[62:0], t[63]} : {t[23:0], t[63:24]};
    return o;
  endfunction

  typedef struct packed {
    logic init;      // load work vector from chain value and counter
    logic final_blk; // invert v14 on init
    logic do_step;   // run one half-G step on all four lanes
    logic diag;      // diagonal half of the round
    logic second;    // second half of G
    logic [RoundW-1:0] rnd;
    logic fold;      // xor work vector into chain value
    logic reset_cv;  // return chain value to start
  } cmd_t;

endpackage

>>> hdl/blake2b_256_hash_top.sv
// Top level of the BLAKE2b hash block (unkeyed, DIGEST_WORDS*8-byte digest).
// Depends on b2b_pkg, b2b_ctrl, b2b_datapath.
//
// Channel  Dir  tdata                         tuser       tlast
// s_axis   in   [63:0] data_word              byte_count  last
// m_axis   out  [63:0] digest_word            word_index  last_word
//
// A word is held in a register, then stored in the block buffer after any
// full block ahead is compressed; no word is taken while one is held. A
// compression (full block ahead of more data, or the final block) is a load
// and 48 half-G steps of the four shared G lanes (12 rounds x 4 steps). The
// digest is then offered one word a cycle while m_axis_tready is high.
// Reset (rst, synchronous) returns the chain value, counter and fill to start.
// Stalls on m_axis hold the current digest word; no input is taken meanwhile.
module blake2b_256_hash_top #(
  parameter int DIGEST_WORDS = b2b_pkg::DigestWordsDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // data_word[63:0]
  input  logic [3:0]  s_axis_tuser,   // byte_count[3:0]
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // digest_word[63:0]
  output logic [1:0]  m_axis_tuser,   // word_index[1:0]
  output logic        m_axis_tlast
);
  import b2b_pkg::*;

  cmd_t cmd;
  logic [127:0] counter;
  logic [64*16-1:0] msg;
  logic [2:0] oidx;

  b2b_ctrl #(.DIGEST_WORDS(DIGEST_WORDS)) u_ctrl (
    .clk, .rst,
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .in_word(s_axis_tdata), .in_count(s_axis_tuser), .in_last(s_axis_tlast),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .out_idx(oidx), .out_lastw(m_axis_tlast),
    .cmd, .counter, .msg
  );

  b2b_datapath #(.DIGEST_WORDS(DIGEST_WORDS)) u_dp (
    .clk, .cmd, .counter, .msg, .rd_idx(oidx), .rd_word(m_axis_tdata)
  );

  assign m_axis_tuser = oidx[1:0];

  // Never take input while the digest is being offered.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready) else $error("input open during output");

  // After the final digest word leaves, the output drops.
  a_out_end: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> !m_axis_tvalid)
    else $error("output continued past last word");

  // Work vector load and rounds never coincide.
  a_cmd_excl: assert property (@(posedge clk) disable iff (rst)
    !(cmd.init && cmd.do_step)) else $error("init during rounds");

endmodule

>>> hdl/b2b_datapath.sv
// Datapath for the BLAKE2b hash block: chain value, work vector, four G lanes.
// Depends on b2b_pkg.
module b2b_datapath #(
  parameter int DIGEST_WORDS = b2b_pkg::DigestWordsDefault
) (
  input  logic              clk,
  input  b2b_pkg::cmd_t     cmd,
  input  logic [127:0]      counter,
  input  logic [64*16-1:0]  msg,
  input  logic [2:0]        rd_idx,
  output logic [63:0]       rd_word
);
  import b2b_pkg::*;

  logic [63:0] cv [8];
  logic [63:0] v [16];
  logic [63:0] sig;
  logic [63:0] vn [16];
  logic [63:0] param;

  assign param = ParamBase | 64'(DIGEST_WORDS * 8);
  assign sig = sigma_row(cmd.rnd);
  assign rd_word = cv[rd_idx];

  always_comb begin
    quad_t q, o;
    int ia, ib, ic, id, ms;
    for (int k = 0; k < 16; k++) vn[k] = v[k];
    for (int l = 0; l < 4; l++) begin
      ia = l;
      ib = cmd.diag ? 4 + ((l + 1) % 4) : 4 + l;
      ic = cmd.diag ? 8 + ((l + 2) % 4) : 8 + l;
      id = cmd.diag ? 12 + ((l + 3) % 4) : 12 + l;
      ms = (cmd.diag ? 8 : 0) + 2 * l + (cmd.second ? 1 : 0);
      q.a = v[ia]; q.b = v[ib]; q.c = v[ic]; q.d = v[id];
      o = g_half(q, msg[64*sig[4*ms +: 4] +: 64], cmd.second);
      vn[ia] = o.a; vn[ib] = o.b; vn[ic] = o.c; vn[id] = o.d;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.reset_cv) begin
      for (int k = 0; k < 8; k++) cv[k] <= iv_word(3'(k));
      cv[0] <= iv_word(3'd0) ^ param;
    end else if (cmd.fold) begin
      // Fold in the work vector as it leaves the last half-step.
      for (int k = 0; k < 8; k++) cv[k] <= cv[k] ^ vn[k] ^ vn[k+8];
    end
    if (cmd.init) begin
      for (int k = 0; k < 8; k++) begin
        v[k] <= cv[k];
        v[k+8] <= iv_word(3'(k));
      end
      v[12] <= iv_word(3'd4) ^ counter[63:0];
      v[13] <= iv_word(3'd5) ^ counter[127:64];
      v[14] <= cmd.final_blk ? ~iv_word(3'd6) : iv_word(3'd6);
    end else if (cmd.do_step) begin
      for (int k = 0; k < 16; k++) v[k] <= vn[k];
    end
  end
endmodule

>>> hdl/b2b_ctrl.sv
// Controller for the BLAKE2b hash block: input buffering, counter, round sequencing, output.
// Depends on b2b_pkg.
module b2b_ctrl #(
  parameter int DIGEST_WORDS = b2b_pkg::DigestWordsDefault
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [63:0]       in_word,
  input  logic [3:0]        in_count,
  input  logic              in_last,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0]        out_idx,
  output logic              out_lastw,
  output b2b_pkg::cmd_t     cmd,
  output logic [127:0]      counter,
  output logic [64*16-1:0]  msg
);
  import b2b_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_INIT = 4'b0010,
    S_RUN  = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  state_t state;
  logic [63:0] buf_w [16];
  logic [7:0] fill;
  logic fin;          // compressing the final block
  logic pend_valid;   // accepted word waiting to be stored
  logic [63:0] pend_word;
  logic [3:0] pend_n;
  logic pend_last;
  logic [RoundW-1:0] rnd;
  logic [1:0] phase;
  logic [2:0] oidx;
  logic [3:0] nsat;
  logic [63:0] mword;
  logic [127:0] cnt_inc;

  assign in_ready = (state == S_IDLE) && !pend_valid;
  assign out_valid = (state == S_OUT);
  assign out_idx = oidx;
  assign out_lastw = (oidx == 3'(DIGEST_WORDS - 1));
  assign counter = cnt_inc;

  always_comb begin
    for (int k = 0; k < 16; k++) msg[64*k +: 64] = buf_w[k];
  end

  // Count saturates at eight; a non-last word always carries eight bytes.
  always_comb begin
    nsat = (!pend_last || pend_n > 4'd8) ? 4'd8 : pend_n;
    mword = pend_word;
    for (int b = 0; b < 8; b++) if (4'(b) >= nsat) mword[8*b +: 8] = 8'h00;
  end

  always_comb begin
    cmd = '0;
    cmd.init = (state == S_INIT);
    cmd.final_blk = fin;
    cmd.do_step = (state == S_RUN);
    cmd.diag = phase[1];
    cmd.second = phase[0];
    cmd.rnd = rnd;
    cmd.fold = (state == S_RUN) && phase == 2'd3 && rnd == RoundW'(NumRounds - 1);
    cmd.reset_cv = rst || (state == S_OUT && out_ready && out_lastw);
  end

  logic [127:0] cnt_reg;
  assign cnt_inc = cnt_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fill <= '0;
      fin <= 1'b0;
      pend_valid <= 1'b0;
      cnt_reg <= '0;
      rnd <= '0;
      phase <= '0;
      oidx <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            pend_valid <= 1'b1;
            pend_word <= in_word;
            pend_n <= in_count;
            pend_last <= in_last;
          end else if (pend_valid) begin
            if (fill[7] && !(pend_last && nsat == 4'd0)) begin
              // Flush a full block before storing more data.
              cnt_reg <= cnt_reg + 128'd128;
              fill <= '0;
              fin <= 1'b0;
              state <= S_INIT;
            end else begin
              pend_valid <= 1'b0;
              if (pend_last) begin
                // Store the tail word and zero every entry above it.
                for (int k = 0; k < 16; k++) begin
                  if (nsat != 4'd0 && 4'(k) == fill[6:3]) buf_w[k] <= mword;
                  else if (8'(k) > ((fill - 8'd1) >> 3) || fill == 8'd0) buf_w[k] <= '0;
                end
                cnt_reg <= cnt_reg + 128'(fill + 8'(nsat));
                fin <= 1'b1;
                state <= S_INIT;
              end else begin
                buf_w[fill[6:3]] <= mword;
                fill <= fill + 8'd8;
              end
            end
          end
        end
        S_INIT: begin
          rnd <= '0;
          phase <= '0;
          state <= S_RUN;
        end
        S_RUN: begin
          phase <= phase + 2'd1;
          if (phase == 2'd3) begin
            rnd <= rnd + RoundW'(1);
            if (rnd == RoundW'(NumRounds - 1)) begin
              state <= fin ? S_OUT : S_IDLE;
              oidx <= '0;
            end
          end
        end
        S_OUT: begin
          if (out_ready) begin
            oidx <= oidx + 3'd1;
            if (out_lastw) begin
              state <= S_IDLE;
              fill <= '0;
              cnt_reg <= '0;
              fin <= 1'b0;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

>>> verif/tb_blake2b_256_hash_top.sv
// Testbench for blake2b_256_hash_top: streams messages of 64-bit words and checks digests.
// Depends on b2b_pkg and the blake2b_256_hash_top RTL; predicts digests with its own BLAKE2b model.
`timescale 1ns / 1ps

module tb_blake2b_256_hash_top;

  localparam int NumDigestWords = 4;
  localparam int IdleLimit = 20000;
  localparam int SettleCycles = 120;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;
  logic [3:0]  s_axis_tuser;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [63:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  typedef struct packed {
    logic [63:0] word;
    logic [1:0]  index;
    logic        final_word;
  } digest_item_t;

  // Golden digest words waiting for the block to produce them.
  digest_item_t digest_queue[$];

  // Predictor state: chain value, 128-bit byte count, block buffer, fill level.
  logic [63:0] hash_state[8];
  logic [63:0] bytes_done[2];
  logic [63:0] msg_block[16];
  int unsigned block_fill;

  int  error_count;
  int  idle_cycles;
  bit  timed_out;

  blake2b_256_hash_top #(.DIGEST_WORDS(NumDigestWords)) u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // data_word[63:0]
    .s_axis_tuser  (s_axis_tuser),   // byte_count[3:0]
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // digest_word[63:0]
    .m_axis_tuser  (m_axis_tuser),   // word_index[1:0]
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic logic [63:0] init_vector(int idx);
    logic [63:0] tab[8];
    tab[0] = 64'h6a09e667f3bcc908; tab[1] = 64'hbb67ae8584caa73b;
    tab[2] = 64'h3c6ef372fe94f82b; tab[3] = 64'ha54ff53a5f1d36f1;
    tab[4] = 64'h510e527fade682d1; tab[5] = 64'h9b05688c2b3e6c1f;
    tab[6] = 64'h1f83d9abfb41bd6b; tab[7] = 64'h5be0cd19137e2179;
    return tab[idx];
  endfunction

  // Message word order for round r mod 10.
  function automatic int sched(int r, int k);
    int rows[10][16];
    rows = '{
      '{ 0,  1,  2,  3,  4,  5,  6,  7,  8,  9, 10, 11, 12, 13, 14, 15},
      '{14, 10,  4,  8,  9, 15, 13,  6,  1, 12,  0,  2, 11,  7,  5,  3},
      '{11,  8, 12,  0,  5,  2, 15, 13, 10, 14,  3,  6,  7,  1,  9,  4},
      '{ 7,  9,  3,  1, 13, 12, 11, 14,  2,  6,  5, 10,  4,  0, 15,  8},
      '{ 9,  0,  5,  7,  2,  4, 10, 15, 14,  1, 11, 12,  6,  8,  3, 13},
      '{ 2, 12,  6, 10,  0, 11,  8,  3,  4, 13,  7,  5, 15, 14,  1,  9},
      '{12,  5,  1, 15, 14, 13,  4, 10,  0,  7,  6,  3,  9,  2,  8, 11},
      '{13, 11,  7, 14, 12,  1,  3,  9,  5,  0, 15,  4,  8,  6,  2, 10},
      '{ 6, 15, 14,  9, 11,  3,  0,  8, 12,  2, 13,  7,  1,  4, 10,  5},
      '{10,  2,  8,  4,  7,  6,  1,  5, 15, 11,  9, 14,  3, 12, 13,  0}};
    return rows[r % 10][k];
  endfunction

  function automatic logic [63:0] ror64(logic [63:0] w, int c);
    return (w >> c) | (w << (64 - c));
  endfunction

  task automatic mix_lane(inout logic [63:0] v[16], input int a, input int b, input int c,
                          input int d, input logic [63:0] x, input logic [63:0] y);
    v[a] = v[a] + v[b] + x;
    v[d] = ror64(v[d] ^ v[a], 32);
    v[c] = v[c] + v[d];
    v[b] = ror64(v[b] ^ v[c], 24);
    v[a] = v[a] + v[b] + y;
    v[d] = ror64(v[d] ^ v[a], 16);
    v[c] = v[c] + v[d];
    v[b] = ror64(v[b] ^ v[c], 63);
  endtask

  task automatic compress(input bit is_final);
    logic [63:0] v[16];
    for (int i = 0; i < 8; i++) begin
      v[i] = hash_state[i];
      v[8 + i] = init_vector(i);
    end
    v[12] ^= bytes_done[0];
    v[13] ^= bytes_done[1];
    if (is_final) v[14] = ~v[14];
    for (int r = 0; r < 12; r++) begin
      mix_lane(v, 0, 4,  8, 12, msg_block[sched(r, 0)],  msg_block[sched(r, 1)]);
      mix_lane(v, 1, 5,  9, 13, msg_block[sched(r, 2)],  msg_block[sched(r, 3)]);
      mix_lane(v, 2, 6, 10, 14, msg_block[sched(r, 4)],  msg_block[sched(r, 5)]);
      mix_lane(v, 3, 7, 11, 15, msg_block[sched(r, 6)],  msg_block[sched(r, 7)]);
      mix_lane(v, 0, 5, 10, 15, msg_block[sched(r, 8)],  msg_block[sched(r, 9)]);
      mix_lane(v, 1, 6, 11, 12, msg_block[sched(r, 10)], msg_block[sched(r, 11)]);
      mix_lane(v, 2, 7,  8, 13, msg_block[sched(r, 12)], msg_block[sched(r, 13)]);
      mix_lane(v, 3, 4,  9, 14, msg_block[sched(r, 14)], msg_block[sched(r, 15)]);
    end
    for (int i = 0; i < 8; i++) hash_state[i] ^= v[i] ^ v[8 + i];
  endtask

  task automatic count_bytes(input logic [63:0] inc);
    bytes_done[0] += inc;
    if (bytes_done[0] < inc) bytes_done[1] += 1;
  endtask

  task automatic restart_hash();
    for (int i = 0; i < 8; i++) hash_state[i] = init_vector(i);
    hash_state[0] ^= 64'h0101_0000 ^ 64'(NumDigestWords * 8);
    bytes_done[0] = '0;
    bytes_done[1] = '0;
    for (int i = 0; i < 16; i++) msg_block[i] = '0;
    block_fill = 0;
  endtask

  // Compress a held full block before more data enters it.
  task automatic drain_full_block();
    if (block_fill >= 128) begin
      count_bytes(128);
      compress(1'b0);
      block_fill = 0;
    end
  endtask

  task automatic predict_word(input logic [63:0] data, input logic [3:0] nbytes,
                              input logic is_last);
    logic [63:0]  w;
    int unsigned  n;
    digest_item_t item;
    w = data;
    if (!is_last) begin
      drain_full_block();
      msg_block[(block_fill >> 3) & 15] = w;
      block_fill += 8;
    end else begin
      n = (nbytes > 8) ? 8 : nbytes;
      if (n > 0) begin
        drain_full_block();
        if (n < 8) w &= (64'd1 << (8 * n)) - 1;
        msg_block[(block_fill >> 3) & 15] = w;
        block_fill += n;
      end
      count_bytes(64'(block_fill));
      for (int i = (block_fill + 7) >> 3; i < 16; i++) msg_block[i] = '0;
      compress(1'b1);
      for (int i = 0; i < NumDigestWords; i++) begin
        item.word       = hash_state[i];
        item.index      = 2'(i);
        item.final_word = (i == NumDigestWords - 1);
        digest_queue.push_back(item);
      end
      restart_hash();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver
  // ---------------------------------------------------------------------------

  int burst_left;

  // Offer one word, wait for its transaction, then predict it. Gaps fall
  // between bursts of random length.
  task automatic send_word(input logic [63:0] data, input logic [3:0] nbytes,
                           input logic is_last);
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tuser  <= nbytes;
    s_axis_tlast  <= is_last;
    do @(posedge clk); while (!(s_axis_tready === 1'b1));
    predict_word(data, nbytes, is_last);
    burst_left--;
  endtask

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // A message of nfull whole words followed by a tail word of tail_bytes.
  task automatic send_message(input int nfull, input logic [3:0] tail_bytes);
    for (int i = 0; i < nfull; i++) send_word(rand_word(), 4'd8, 1'b0);
    send_word(rand_word(), tail_bytes, 1'b1);
  endtask

  task automatic wait_digests_drained();
    s_axis_tvalid <= 1'b0;
    while (digest_queue.size() != 0 && !timed_out) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Empty message, field extremes, tail lengths 0, 1, 5, 7 and 8 and oversized counts.
  task automatic test_directed_edges();
    send_word(64'h0, 4'd0, 1'b1);
    send_word(64'hffff_ffff_ffff_ffff, 4'd8, 1'b1);
    send_word(64'h0, 4'd8, 1'b1);
    send_word(64'hffff_ffff_ffff_ffff, 4'd15, 1'b1);
    send_word(64'hffff_ffff_ffff_ffff, 4'd1, 1'b1);
    send_word(64'hffff_ffff_ffff_ffff, 4'd7, 1'b1);
    // Non-last word with a short count still counts as eight bytes.
    send_word(64'h0123_4567_89ab_cdef, 4'd3, 1'b0);
    send_word(64'h0, 4'd0, 1'b1);
    send_word(64'hfedc_ba98_7654_3210, 4'd9, 1'b0);
    send_word(64'haaaa_5555_aaaa_5555, 4'd5, 1'b1);
    send_word(64'h5555_aaaa_5555_aaaa, 4'd12, 1'b1);
  endtask

  // Block boundaries: exactly one block, one block plus empty tail, one block plus four bytes, two blocks.
  task automatic test_block_boundaries();
    send_message(15, 4'd8);
    send_message(16, 4'd0);
    send_message(16, 4'd4);
    wait_digests_drained();
    send_message(31, 4'd8);
  endtask

  // Random messages (tail counts 0 to 15), mostly short, some spanning several blocks.
  task automatic test_random_messages(input int budget);
    int used;
    int nfull;
    used = 0;
    while (used < budget) begin
      if ($urandom_range(0, 9) == 0) nfull = $urandom_range(14, 40);
      else nfull = $urandom_range(0, 5);
      send_message(nfull, 4'($urandom_range(0, 15)));
      used += nfull + 1;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver, checker and watchdog
  // ---------------------------------------------------------------------------

  // Stall on a pattern of its own: periods of steady ready alternate with
  // randomly gated periods.
  int stall_phase;
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b1;
      stall_phase   <= 0;
    end else begin
      stall_phase <= (stall_phase + 1) % 64;
      if (stall_phase < 24) m_axis_tready <= 1'b1;
      else m_axis_tready <= ($urandom_range(0, 2) != 0);
    end
  end

  always @(posedge clk) begin
    digest_item_t golden;
    if (!rst && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
      if (digest_queue.size() == 0) begin
        $error("unexpected digest word %h", m_axis_tdata);
        error_count++;
      end else begin
        golden = digest_queue.pop_front();
        if (m_axis_tdata !== golden.word) begin
          $error("digest_word expected %h actual %h", golden.word, m_axis_tdata);
          error_count++;
        end
        if (m_axis_tuser !== golden.index) begin
          $error("word_index expected %0d actual %0d", golden.index, m_axis_tuser);
          error_count++;
        end
        if (m_axis_tlast !== golden.final_word) begin
          $error("last_word expected %0d actual %0d", golden.final_word, m_axis_tlast);
          error_count++;
        end
      end
    end
  end

  // Count cycles with no transaction on either side.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) timed_out <= 1'b1;
  end

  initial begin
    wait (timed_out);
    $display("blake2b_256_hash_top: mismatch");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    s_axis_tlast  <= 1'b0;
    burst_left  = 0;
    restart_hash();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_edges();
    wait_digests_drained();
    test_block_boundaries();
    test_random_messages(85);
    s_axis_tvalid <= 1'b0;

    while (digest_queue.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);

    if (error_count == 0) $display("blake2b_256_hash_top: match");
    else $display("blake2b_256_hash_top: mismatch");
    $finish;
  end

endmodule
